@@ src/rde_pkg.sv @@
// shared types and constants for the restricted deque engine
// no dependencies; imported by every module of the block except rde_ram
package rde_pkg;

  // action codes on the input channel
  localparam logic [2:0] ACT_CHECK      = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_POP_REAR   = 3'd4;
  localparam logic [2:0] ACT_SHOW       = 3'd5;

  // restriction mode codes
  localparam logic MODE_IN_RESTRICT  = 1'b0;
  localparam logic MODE_OUT_RESTRICT = 1'b1;

  // width of the element_count field
  localparam int CNT_W = 6;

  // result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_CHECK      = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4,
    OP_SHOW       = 3'd5,
    OP_DENY       = 3'd6
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

endpackage

@@ src/restricted_deque_engine_top.sv @@
// Restricted double-ended queue of signed 32-bit words held in a ring ram of
// DEPTH entries. Check, insert, and any refused or failed action are done in
// the back end's idle state and return one word. A delete reads the ram in the
// idle state and loads the result in the emit state. A display returns one
// word per element, front to rear, after an initial ram read; an empty display
// returns one word. The element ram has a single read port, so a display reads
// one element at a time. A front stage and a two-entry command queue keep
// accepting words while the back end is busy. cfg_wr_data picks the mode: 0
// refuses front insert, 1 refuses rear delete; write it only while the block
// is idle. The ram needs no clearing after reset.
// depends on rde_pkg, rde_front, rde_cmd_q, rde_back, rde_ram
module restricted_deque_engine_top
  import rde_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [32] is_empty,
                                  // [38:33] element_count, [39] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  logic             mode_r, mode_nxt;
  logic             f_valid, f_ready;
  cmd_t             f_cmd;
  logic             q_valid, q_ready;
  cmd_t             q_cmd;
  status_t          b_status;
  logic [31:0]      b_value;
  logic             b_empty;
  logic [CNT_W-1:0] b_count;

  // mode register
  always_comb begin
    mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IN_RESTRICT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  rde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  rde_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  rde_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (b_status),
    .out_value  (b_value),
    .out_empty  (b_empty),
    .out_count  (b_count),
    .out_last   (out_tlast)
  );

  // pack result word
  assign out_tdata = {1'b0, b_count, b_empty, b_value};
  assign out_tuser = b_status;

endmodule

@@ src/rde_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module rde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ src/rde_front.sv @@
// front end: accepts input words, checks the restriction mode, registers a command
// depends on rde_pkg
module rde_front
  import rde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_value,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic vld_r, vld_nxt;
  cmd_t cmd_r;
  op_t  op_dec;

  // classify the action against the mode
  always_comb begin
    unique case (in_action)
      ACT_CHECK:      op_dec = OP_CHECK;
      ACT_PUSH_REAR:  op_dec = OP_PUSH_REAR;
      ACT_PUSH_FRONT: op_dec = (mode == MODE_IN_RESTRICT) ? OP_DENY : OP_PUSH_FRONT;
      ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
      ACT_POP_REAR:   op_dec = (mode == MODE_OUT_RESTRICT) ? OP_DENY : OP_POP_REAR;
      ACT_SHOW:       op_dec = OP_SHOW;
      default:        op_dec = OP_DENY;
    endcase
  end

  assign in_ready  = !vld_r || cmd_ready;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

  // one-word holding stage
  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r.op    <= op_dec;
      cmd_r.value <= in_value;
    end
  end

endmodule

@@ src/rde_cmd_q.sv @@
// two-entry command queue between front and back
// depends on rde_pkg
module rde_cmd_q
  import rde_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_cmd   = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and fill update
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

@@ src/rde_back.sv @@
// back end: owns the ring pointers and the element ram, executes commands
// depends on rde_pkg and rde_ram
module rde_back
  import rde_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     out_status,
  output logic [31:0] out_value,
  output logic        out_empty,
  output logic [CNT_W-1:0] out_count,
  output logic        out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          show_r, show_nxt;

  logic            o_vld_r, o_vld_nxt;
  status_t         o_status_r, o_status_nxt;
  logic [31:0]     o_value_r, o_value_nxt;
  logic            o_empty_r;
  logic [CNT_W-1:0] o_count_r;
  logic            o_last_r, o_last_nxt;
  logic            o_load;

  logic [AW:0]      tail_sum;
  logic [AW-1:0]    tail, rear, head_dec, ptr_inc;
  logic [CW+CNT_W-1:0] occ_wide;
  logic             is_full, is_empty, out_free, emit_last;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_data;

  rde_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ring arithmetic
  assign tail_sum = {1'b0, head_r} + (AW+1)'(occ_r);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign rear     = (tail == '0) ? LAST_IX : tail - AW'(1);
  assign head_dec = (head_r == '0) ? LAST_IX : head_r - AW'(1);
  assign ptr_inc  = (ptr_r == LAST_IX) ? '0 : ptr_r + AW'(1);
  assign is_full  = (occ_r == FULL_C);
  assign is_empty = (occ_r == '0);
  assign out_free = !o_vld_r || out_ready;
  assign emit_last = !show_r || (idx_r + CW'(1) == occ_r);

  assign cmd_ready = (state_r == S_IDLE) && out_free;

  // command execution
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    ptr_nxt      = ptr_r;
    idx_nxt      = idx_r;
    show_nxt     = show_r;
    wr_en        = 1'b0;
    wr_addr      = tail;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    o_load       = 1'b0;
    o_status_nxt = ST_OK;
    o_value_nxt  = '0;
    o_last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          unique case (cmd.op)
            OP_CHECK: begin
              o_load = 1'b1;
            end
            OP_PUSH_REAR: begin
              o_load = 1'b1;
              if (is_full) begin
                o_status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = tail;
                occ_nxt = occ_r + CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              o_load = 1'b1;
              if (is_full) begin
                o_status_nxt = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = head_dec;
                head_nxt = head_dec;
                occ_nxt  = occ_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                o_load       = 1'b1;
                o_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                head_nxt  = (head_r == LAST_IX) ? '0 : head_r + AW'(1);
                occ_nxt   = occ_r - CW'(1);
                show_nxt  = 1'b0;
                state_nxt = S_EMIT;
              end
            end
            OP_POP_REAR: begin
              if (is_empty) begin
                o_load       = 1'b1;
                o_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = rear;
                occ_nxt   = occ_r - CW'(1);
                show_nxt  = 1'b0;
                state_nxt = S_EMIT;
              end
            end
            OP_SHOW: begin
              if (is_empty) begin
                o_load       = 1'b1;
                o_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                ptr_nxt   = head_r;
                idx_nxt   = '0;
                show_nxt  = 1'b1;
                state_nxt = S_EMIT;
              end
            end
            default: begin
              o_load       = 1'b1;
              o_status_nxt = ST_DENIED;
            end
          endcase
        end
      end
      S_EMIT: begin
        // read data is held until the output stage can take it
        if (out_free) begin
          o_load      = 1'b1;
          o_value_nxt = rd_data;
          o_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
            ptr_nxt = ptr_inc;
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    o_vld_nxt = o_vld_r;
    if (o_load) begin
      o_vld_nxt = 1'b1;
    end else if (out_ready) begin
      o_vld_nxt = 1'b0;
    end
  end

  assign occ_wide = {{CNT_W{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      o_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // walk position and output payload
  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    idx_r  <= idx_nxt;
    show_r <= show_nxt;
    if (o_load) begin
      o_status_r <= o_status_nxt;
      o_value_r  <= o_value_nxt;
      o_last_r   <= o_last_nxt;
      o_empty_r  <= (occ_nxt == '0);
      o_count_r  <= occ_wide[CNT_W-1:0];
    end
  end

  assign out_valid  = o_vld_r;
  assign out_status = o_status_r;
  assign out_value  = o_value_r;
  assign out_empty  = o_empty_r;
  assign out_count  = o_count_r;
  assign out_last   = o_last_r;

endmodule

@@ verif/restricted_deque_engine_top_test.sv @@
// self-checking testbench for restricted_deque_engine_top: random and directed deque actions,
// with results predicted by a mirror of the ring store and compared word by word
// depends on rde_pkg and the restricted_deque_engine_top rtl
`timescale 1ns / 1ps

module restricted_deque_engine_top_test;
  import rde_pkg::*;

  localparam int RING_DEPTH = 32;
  localparam int GAP_MAX = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  typedef struct {
    status_t          status;
    logic [31:0]      value;
    logic             empty;
    logic [CNT_W-1:0] count;
    logic             last;
  } deque_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [2:0]  in_tuser = '0;   // [2:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] result_value, [32] is_empty, [38:33] element_count
  logic [1:0]  out_tuser;       // [1:0] status
  logic        out_tlast;

  // mirror of the deque contents and mode
  logic [31:0] mirror_ring [RING_DEPTH];
  int          mirror_head = 0;
  int          mirror_fill = 0;
  logic        mirror_mode = MODE_IN_RESTRICT;

  deque_word_t owed_words[$];
  int          err_count = 0;
  int          send_calm = 0;
  int          recv_calm = 0;

  restricted_deque_engine_top #(.DEPTH(RING_DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // idle cycles before a word, with stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // grow leans towards inserts, otherwise towards deletes
  function automatic logic [2:0] pick_action(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return ACT_CHECK;
    if (r < 8) return ACT_SHOW;
    if (r < 12) return r[0] ? ACT_UNUSED_6 : ACT_UNUSED_7;
    if (r < 56) return grow ? ACT_PUSH_REAR : ACT_POP_FRONT;
    if (r < 80) return grow ? ACT_PUSH_FRONT : ACT_POP_REAR;
    if (r < 90) return grow ? ACT_POP_FRONT : ACT_PUSH_REAR;
    return grow ? ACT_POP_REAR : ACT_PUSH_FRONT;
  endfunction

  function automatic void owe_word(status_t st, logic [31:0] v, logic lst);
    deque_word_t w;
    w.status = st;
    w.value  = v;
    w.empty  = (mirror_fill == 0);
    w.count  = CNT_W'(mirror_fill);
    w.last   = lst;
    owed_words.push_back(w);
  endfunction

  // apply one accepted action to the mirror and queue the words it owes
  function automatic void mirror_action(logic [2:0] act, logic [31:0] v);
    logic [31:0] got;
    case (act)
      ACT_CHECK: owe_word(ST_OK, '0, 1'b1);
      ACT_PUSH_REAR: begin
        if (mirror_fill >= RING_DEPTH) begin
          owe_word(ST_FULL, '0, 1'b1);
        end else begin
          mirror_ring[(mirror_head + mirror_fill) % RING_DEPTH] = v;
          mirror_fill++;
          owe_word(ST_OK, '0, 1'b1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (mirror_mode == MODE_IN_RESTRICT) begin
          owe_word(ST_DENIED, '0, 1'b1);
        end else if (mirror_fill >= RING_DEPTH) begin
          owe_word(ST_FULL, '0, 1'b1);
        end else begin
          mirror_head = (mirror_head + RING_DEPTH - 1) % RING_DEPTH;
          mirror_ring[mirror_head] = v;
          mirror_fill++;
          owe_word(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT: begin
        if (mirror_fill == 0) begin
          owe_word(ST_EMPTY, '0, 1'b1);
        end else begin
          got = mirror_ring[mirror_head];
          mirror_head = (mirror_head + 1) % RING_DEPTH;
          mirror_fill--;
          owe_word(ST_OK, got, 1'b1);
        end
      end
      ACT_POP_REAR: begin
        if (mirror_mode == MODE_OUT_RESTRICT) begin
          owe_word(ST_DENIED, '0, 1'b1);
        end else if (mirror_fill == 0) begin
          owe_word(ST_EMPTY, '0, 1'b1);
        end else begin
          got = mirror_ring[(mirror_head + mirror_fill - 1) % RING_DEPTH];
          mirror_fill--;
          owe_word(ST_OK, got, 1'b1);
        end
      end
      ACT_SHOW: begin
        if (mirror_fill == 0) begin
          owe_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < mirror_fill; i++)
            owe_word(ST_OK, mirror_ring[(mirror_head + i) % RING_DEPTH],
                     i == mirror_fill - 1);
        end
      end
      default: owe_word(ST_DENIED, '0, 1'b1);
    endcase
  endfunction

  // present one word after a random gap and hold it until taken
  task automatic send_word(logic [2:0] act, logic [31:0] v);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= v;
    do @(posedge clk); while (in_tready !== 1'b1);
    mirror_action(act, v);
  endtask

  // stop sending until every owed word has come back and the block has settled
  task automatic wait_all_owed();
    in_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    wait_all_owed();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mirror_mode = m;
  endtask

  // empty queue: every action that can fail on it, plus the unused codes
  task automatic test_idle_queue();
    send_word(ACT_CHECK, draw_value());
    send_word(ACT_POP_FRONT, draw_value());
    send_word(ACT_POP_REAR, draw_value());
    send_word(ACT_SHOW, draw_value());
    send_word(ACT_UNUSED_6, draw_value());
    send_word(ACT_UNUSED_7, draw_value());
    send_word(ACT_PUSH_FRONT, 32'h1234_5678);
  endtask

  // extreme element values, and deleting the only element from either end
  task automatic test_extreme_values();
    send_word(ACT_PUSH_REAR, 32'h8000_0000);
    send_word(ACT_PUSH_REAR, 32'h7fff_ffff);
    send_word(ACT_PUSH_REAR, 32'h0000_0000);
    send_word(ACT_PUSH_REAR, 32'hffff_ffff);
    send_word(ACT_SHOW, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_CHECK, '0);
    send_word(ACT_PUSH_REAR, 32'h5a5a_a5a5);
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_CHECK, '0);
  endtask

  // output restricted: rear delete refused even when empty, front insert allowed
  task automatic test_mode_rules();
    set_mode(MODE_OUT_RESTRICT);
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_PUSH_FRONT, draw_value());
    send_word(ACT_PUSH_FRONT, draw_value());
    send_word(ACT_PUSH_REAR, draw_value());
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_SHOW, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_FRONT, '0);
  endtask

  // fill the ring from both ends, hit full, refusal before full, then drain
  task automatic test_full_ring();
    set_mode(MODE_OUT_RESTRICT);
    while (mirror_fill < RING_DEPTH)
      send_word($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, draw_value());
    send_word(ACT_PUSH_REAR, draw_value());
    send_word(ACT_PUSH_FRONT, draw_value());
    send_word(ACT_SHOW, '0);
    send_word(ACT_CHECK, '0);
    set_mode(MODE_IN_RESTRICT);
    send_word(ACT_PUSH_FRONT, draw_value());
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_PUSH_REAR, draw_value());
    while (mirror_fill > 0)
      send_word($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, '0);
    send_word(ACT_SHOW, '0);
  endtask

  // phases alternating between growing and shrinking the deque, random mode
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      set_mode(1'($urandom_range(0, 1)));
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 49) == 0) wait_all_owed();
        send_word(pick_action(phase % 2 == 0), draw_value());
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  // take result words with random stalls and compare each with the oldest owed one
  initial begin : result_checker
    deque_word_t want;
    int stall;
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (owed_words.size() == 0) begin
        $error("result word with none owed: tdata %0h tuser %0h", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = owed_words.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("result_value", want.value, out_tdata[31:0]);
        check_field("is_empty", 32'(want.empty), 32'(out_tdata[32]));
        check_field("element_count", 32'(want.count), 32'(out_tdata[38:33]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_queue();
    test_extreme_values();
    test_mode_rules();
    test_full_ring();
    test_random_traffic();
    wait_all_owed();
    if (err_count == 0)
      $display("PASS restricted_deque_engine_top");
    else
      $display("FAIL restricted_deque_engine_top");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("FAIL restricted_deque_engine_top");
    $finish;
  end

endmodule

@@ files.f @@
src/rde_pkg.sv
src/rde_ram.sv
src/rde_front.sv
src/rde_cmd_q.sv
src/rde_back.sv
src/restricted_deque_engine_top.sv
verif/restricted_deque_engine_top_test.sv
